// File: rtl/hta_pkg.sv
// Shared types, codes and reset-pattern function for the handle table allocator.
`default_nettype none

package hta_pkg;

    localparam int HANDLE_COUNT = 256;
    localparam int HW           = $clog2(HANDLE_COUNT);
    localparam int OBJ_W        = 32;

    // operation codes
    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_SET     = 2'd2;
    localparam logic [1:0] KIND_GET     = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FREE = 2'd1;
    localparam logic [1:0] ST_NULL    = 2'd2;

    // one table entry: reference plus both list links
    typedef struct packed {
        logic [OBJ_W-1:0] obj;
        logic [HW-1:0]    prev;
        logic [HW-1:0]    next;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // entry contents written by the init sweep after reset: forward and backward free chain
    function automatic t_entry init_entry(input logic [HW-1:0] n);
        t_entry e;
        e.obj  = '0;
        e.next = (n == '0 || n == HW'(HANDLE_COUNT - 1)) ? '0 : n + HW'(1);
        e.prev = (n >= HW'(2)) ? n - HW'(1) : '0;
        return e;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hta_ram.sv
// Generic single-port-write, single-port-read RAM with bit write enables.
`default_nettype none

module hta_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wmask,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int b = 0; b < WIDTH; b++) begin
                if (i_wmask[b]) begin
                    mem[i_waddr][b] <= i_wdata[b];
                end
            end
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/handle_table_allocator.sv
// Top level: handle table with free list and in-use list kept in one entry RAM.
//
//  channel  | ports                                      | handshake
//  ---------+--------------------------------------------+------------------------------
//  command  | i_kind, i_handle, i_object_ref             | beat when i_start && !o_busy
//  result   | o_handle_out, o_ref_out, o_status,         | one-cycle beat on o_done,
//           | o_dec_valid/o_dec_ref, o_inc_valid/o_inc_ref| no back-pressure
//
// Each command runs as a sequence of steps after it is accepted. The steps are
// set by the single write port of the entry RAM: each link or table update is
// its own write step, so a release needs more steps than an allocate, while set,
// get and ignored commands finish in their first step. Reset runs an init sweep
// that writes the free chain into the RAM; o_busy is high throughout.
// The result beat shows while o_busy is already low, so the next command can
// be taken in that same cycle. Results cannot be stalled.
`default_nettype none

module handle_table_allocator
    import hta_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [1:0]       i_kind,
    input  wire logic [7:0]       i_handle,
    input  wire logic [OBJ_W-1:0] i_object_ref,
    output logic                  o_busy,
    output logic                  o_done,
    output logic      [7:0]       o_handle_out,
    output logic      [OBJ_W-1:0] o_ref_out,
    output logic      [1:0]       o_status,
    output logic                  o_dec_valid,
    output logic      [OBJ_W-1:0] o_dec_ref,
    output logic                  o_inc_valid,
    output logic      [OBJ_W-1:0] o_inc_ref
);

    localparam logic [1:0] S_INIT = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_STEP = 2'd2;

    // sequencer control
    logic [1:0]       r_state, n_state;
    logic [1:0]       r_step,  n_step;
    logic [HW-1:0]    r_cnt,   n_cnt;
    logic [HW-1:0]    r_free_head, n_free_head;
    logic [HW-1:0]    r_used_head, n_used_head;

    // captured command
    logic [1:0]       r_kind;
    logic [7:0]       r_hin;
    logic [HW-1:0]    r_addr;
    logic [OBJ_W-1:0] r_obj;
    logic             r_skip;

    // fields of the entry read at step 0
    logic [HW-1:0]    r_nx, r_pv;
    logic [OBJ_W-1:0] r_old;

    // result registers
    logic             r_done, n_done;
    logic [7:0]       r_hout, n_hout;
    logic [OBJ_W-1:0] r_rout, n_rout;
    logic [1:0]       r_status, n_status;
    logic             r_decv, n_decv;
    logic [OBJ_W-1:0] r_decr, n_decr;
    logic             r_incv, n_incv;
    logic [OBJ_W-1:0] r_incr, n_incr;

    // RAM port
    logic                 mem_we;
    logic [HW-1:0]        mem_waddr, mem_raddr;
    t_entry               mem_wmask, mem_wdata, rd;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic accept, fin, null_h;

    assign accept = i_start && (r_state == S_IDLE);
    assign rd     = t_entry'(ram_rdata);
    assign null_h = (i_handle == 8'd0) || (32'(i_handle) >= 32'(HANDLE_COUNT));

    // read address is presented in the accept cycle; data is ready at step 0
    assign mem_raddr = (i_kind == KIND_ALLOC) ? r_free_head : HW'(i_handle);

    hta_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HANDLE_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wmask (mem_wmask),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_free_head = r_free_head;
        n_used_head = r_used_head;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wmask   = '0;
        mem_wdata   = '0;
        fin         = 1'b0;

        unique case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wmask = '1;
                mem_wdata = init_entry(r_cnt);
                n_cnt     = r_cnt + HW'(1);
                if (r_cnt == HW'(HANDLE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_STEP;
                    n_step  = '0;
                end
            end
            S_STEP: begin
                n_step = r_step + 2'd1;
                if (r_skip) begin
                    fin = 1'b1;
                end else begin
                    unique case (r_kind)
                        KIND_ALLOC: begin
                            unique case (r_step)
                                2'd0: begin
                                    // new free head loses its back link
                                    mem_we         = (rd.next != '0);
                                    mem_waddr      = rd.next;
                                    mem_wmask.prev = '1;
                                end
                                2'd1: begin
                                    // old in-use head points back to the new one
                                    mem_we         = (r_used_head != '0);
                                    mem_waddr      = r_used_head;
                                    mem_wmask.prev = '1;
                                    mem_wdata.prev = r_addr;
                                end
                                default: begin
                                    mem_we         = 1'b1;
                                    mem_waddr      = r_addr;
                                    mem_wmask      = '1;
                                    mem_wdata.obj  = r_obj;
                                    mem_wdata.next = r_used_head;
                                    n_used_head    = r_addr;
                                    n_free_head    = r_nx;
                                    fin            = 1'b1;
                                end
                            endcase
                        end
                        KIND_RELEASE: begin
                            unique case (r_step)
                                2'd0: begin
                                    mem_we         = (rd.next != '0);
                                    mem_waddr      = rd.next;
                                    mem_wmask.prev = '1;
                                    mem_wdata.prev = rd.prev;
                                end
                                2'd1: begin
                                    if (r_pv != '0) begin
                                        mem_we         = 1'b1;
                                        mem_waddr      = r_pv;
                                        mem_wmask.next = '1;
                                        mem_wdata.next = r_nx;
                                    end else begin
                                        n_used_head = r_nx;
                                    end
                                end
                                2'd2: begin
                                    // entry goes to the front of the free list
                                    mem_we         = 1'b1;
                                    mem_waddr      = r_addr;
                                    mem_wmask      = '1;
                                    mem_wdata.next = r_free_head;
                                end
                                default: begin
                                    mem_we         = (r_free_head != '0);
                                    mem_waddr      = r_free_head;
                                    mem_wmask.prev = '1;
                                    mem_wdata.prev = r_addr;
                                    n_free_head    = r_addr;
                                    fin            = 1'b1;
                                end
                            endcase
                        end
                        KIND_SET: begin
                            mem_we        = 1'b1;
                            mem_waddr     = r_addr;
                            mem_wmask.obj = '1;
                            mem_wdata.obj = r_obj;
                            fin           = 1'b1;
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
                if (fin) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result fields, loaded on the last sequencer cycle
    always_comb begin
        n_done   = fin;
        n_hout   = r_hout;
        n_rout   = r_rout;
        n_status = r_status;
        n_decv   = r_decv;
        n_decr   = r_decr;
        n_incv   = r_incv;
        n_incr   = r_incr;
        if (fin) begin
            n_hout   = r_hin;
            n_rout   = '0;
            n_status = ST_OK;
            n_decv   = 1'b0;
            n_decr   = '0;
            n_incv   = 1'b0;
            n_incr   = '0;
            if (r_kind == KIND_ALLOC) begin
                n_hout = r_skip ? 8'd0 : 8'(r_addr);
            end
            if (r_skip) begin
                n_status = (r_kind == KIND_ALLOC) ? ST_NO_FREE : ST_NULL;
            end else begin
                unique case (r_kind)
                    KIND_ALLOC: begin
                        n_incv = (r_obj != '0);
                        n_incr = r_obj;
                    end
                    KIND_RELEASE: begin
                        n_decv = (r_old != '0);
                        n_decr = r_old;
                    end
                    KIND_SET: begin
                        n_decv = (rd.obj != '0);
                        n_decr = rd.obj;
                        n_incv = (r_obj != '0);
                        n_incr = r_obj;
                    end
                    default: begin
                        n_rout = rd.obj;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_step      <= '0;
            r_cnt       <= '0;
            r_free_head <= HW'(1);
            r_used_head <= '0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_cnt       <= n_cnt;
            r_free_head <= n_free_head;
            r_used_head <= n_used_head;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind <= i_kind;
            r_hin  <= i_handle;
            r_obj  <= i_object_ref;
            r_addr <= (i_kind == KIND_ALLOC) ? r_free_head : HW'(i_handle);
            r_skip <= (i_kind == KIND_ALLOC) ? (r_free_head == '0) : null_h;
        end
        if (r_state == S_STEP && r_step == 2'd0) begin
            r_nx  <= rd.next;
            r_pv  <= rd.prev;
            r_old <= rd.obj;
        end
        r_hout   <= n_hout;
        r_rout   <= n_rout;
        r_status <= n_status;
        r_decv   <= n_decv;
        r_decr   <= n_decr;
        r_incv   <= n_incv;
        r_incr   <= n_incr;
    end

    assign o_busy       = (r_state != S_IDLE);
    assign o_done       = r_done;
    assign o_handle_out = r_hout;
    assign o_ref_out    = r_rout;
    assign o_status     = r_status;
    assign o_dec_valid  = r_decv;
    assign o_dec_ref    = r_decr;
    assign o_inc_valid  = r_incv;
    assign o_inc_ref    = r_incr;

`ifndef SYNTH
    // a taken command keeps the block busy until its result
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("command taken but block not busy");

    // a result only follows sequencer work
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(o_busy) && !o_busy))
        else $error("result beat without preceding work");

    // refused commands report no count events
    a_no_events_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != ST_OK) |-> (!o_dec_valid && !o_inc_valid))
        else $error("count event on refused command");

    // exhausted allocate returns the null handle
    a_no_free_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_NO_FREE) |-> (o_handle_out == 8'd0))
        else $error("no-free result with non-null handle");

    // only a get returns a reference
    a_ref_only_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_ref_out != '0) |-> (r_kind == KIND_GET && !r_skip))
        else $error("reference returned by non-get command");
`endif

endmodule

`default_nettype wire
